// ----- rtl/nkro_key_report_builder_macros.svh -----
// Assertion macros used by the keyboard report builder controller.
// Each macro expects a clk and rst in scope at the point of use.
`ifndef NKRO_KEY_REPORT_BUILDER_MACROS_SVH
`define NKRO_KEY_REPORT_BUILDER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define NKRO_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define NKRO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/nkro_pkg.sv -----
// Shared constants, command codes and control/status structs for the
// keyboard report builder. No dependencies.
package nkro_pkg;

  localparam int KEY_COUNT    = 160;
  localparam int BITMAP_BYTES = 20;
  localparam int BMP_IDX_W    = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int REPORT_LEN   = 3 + BITMAP_BYTES;
  localparam int IDX_W        = 5;
  localparam int S_TDATA_W    = 40;
  localparam int M_TDATA_W    = 16;

  // Command codes carried in s_tuser
  localparam logic [2:0] CMD_KEY       = 3'd0;
  localparam logic [2:0] CMD_MODS      = 3'd1;
  localparam logic [2:0] CMD_CONSUMER  = 3'd2;
  localparam logic [2:0] CMD_CLEAR     = 3'd3;
  localparam logic [2:0] CMD_SERIALIZE = 3'd4;

  // Report ids
  localparam logic [7:0] KIND_KEYBOARD = 8'h01;
  localparam logic [7:0] KIND_CONSUMER = 8'h02;

  // Controller to datapath
  typedef struct packed {
    logic take;   // input word accepted this cycle
    logic start;  // restart byte counter
    logic emit;   // load next report byte into output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ser_go;    // current input is serialize with a known report kind
    logic ser_last;  // byte counter points at final report byte
  } dp_stat_t;

endpackage

// ----- rtl/nkro_datapath.sv -----
// Datapath: key bitmap, modifier and consumer registers, report id,
// byte counter and output register. Depends on nkro_pkg.
module nkro_datapath
  import nkro_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ctrl_cmd_t        cmd_i,
  output dp_stat_t         stat,
  input  logic [2:0]       cmd,
  input  logic [7:0]       key_code,
  input  logic             pressed,
  input  logic [7:0]       mod_bits,
  input  logic [15:0]      consumer_code,
  input  logic             cfg_wr,
  input  logic [7:0]       cfg_data,
  output logic [7:0]       out_byte,
  output logic [IDX_W-1:0] byte_index,
  output logic             last
);

  logic [7:0]       key_bitmap [BITMAP_BYTES];
  logic [7:0]       modifier_byte;
  logic [15:0]      consumer_value;
  logic [7:0]       report_kind;
  logic [IDX_W-1:0] idx;

  logic             key_ok;
  logic [IDX_W-1:0] bmp_off;
  logic [7:0]       bmp_rd;
  logic [7:0]       byte_sel;

  // Key event lands in the bitmap only for codes inside the bitmap
  assign key_ok = ({1'b0, key_code} < 9'(KEY_COUNT)) &&
                  ({1'b0, key_code[7:3]} < 6'(BITMAP_BYTES));

  // Bitmap, modifier and consumer state
  always_ff @(posedge clk) begin
    if (rst || (cmd_i.take && cmd == CMD_CLEAR)) begin
      for (int i = 0; i < BITMAP_BYTES; i++) begin
        key_bitmap[i] <= 8'h00;
      end
      modifier_byte  <= 8'h00;
      consumer_value <= 16'h0000;
    end else if (cmd_i.take) begin
      if (cmd == CMD_KEY && key_ok) begin
        key_bitmap[key_code[3 +: BMP_IDX_W]][key_code[2:0]] <= pressed;
      end
      if (cmd == CMD_MODS) begin
        modifier_byte <= mod_bits;
      end
      if (cmd == CMD_CONSUMER) begin
        consumer_value <= consumer_code;
      end
    end
  end

  // Report id register
  always_ff @(posedge clk) begin
    if (rst) begin
      report_kind <= KIND_KEYBOARD;
    end else if (cfg_wr) begin
      report_kind <= cfg_data;
    end
  end

  // Byte counter
  always_ff @(posedge clk) begin
    if (rst || cmd_i.start) begin
      idx <= '0;
    end else if (cmd_i.emit) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Select the report byte at the counter
  assign bmp_off = idx - IDX_W'(3);

  always_comb begin
    bmp_rd = 8'h00;
    if (idx >= IDX_W'(3) && {1'b0, bmp_off} < (IDX_W + 1)'(BITMAP_BYTES)) begin
      bmp_rd = key_bitmap[bmp_off[BMP_IDX_W-1:0]];
    end
  end

  always_comb begin
    priority if (idx == IDX_W'(0)) begin
      byte_sel = report_kind;
    end else if (idx == IDX_W'(1)) begin
      byte_sel = (report_kind == KIND_KEYBOARD) ? modifier_byte : consumer_value[7:0];
    end else if (idx == IDX_W'(2)) begin
      byte_sel = (report_kind == KIND_KEYBOARD) ? 8'h00 : consumer_value[15:8];
    end else begin
      byte_sel = bmp_rd;
    end
  end

  // Status to controller
  assign stat.ser_go   = (cmd == CMD_SERIALIZE) &&
                         (report_kind == KIND_KEYBOARD || report_kind == KIND_CONSUMER);
  assign stat.ser_last = (report_kind == KIND_KEYBOARD && idx == IDX_W'(REPORT_LEN - 1)) ||
                         (report_kind == KIND_CONSUMER && idx == IDX_W'(2));

  // Output register
  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_byte   <= byte_sel;
      byte_index <= idx;
      last       <= stat.ser_last;
    end
  end

endmodule

// ----- rtl/nkro_ctrl.sv -----
// Controller: accepts command words and steps the serializer one report
// byte per cycle unless stalled. Depends on nkro_pkg and assertion macros.
`include "nkro_key_report_builder_macros.svh"

module nkro_ctrl
  import nkro_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic {IDLE, SER} state_t;

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;

  // Take words only between reports; emit when the output slot frees up
  assign s_tready    = (state == IDLE);
  assign cmd_o.take  = s_tvalid && s_tready;
  assign cmd_o.start = cmd_o.take && stat.ser_go;
  assign cmd_o.emit  = (state == SER) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: if (cmd_o.start) begin
        state_next = SER;
      end
      SER: if (cmd_o.emit && stat.ser_last) begin
        state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd_o.emit) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  `NKRO_ASSERT(a_take_idle, cmd_o.take, state == IDLE, "word taken during a report")
  `NKRO_ASSERT_NEXT(a_start_ser, cmd_o.start, state == SER && m_tvalid == $past(m_tvalid && !m_tready), "report did not start")
  `NKRO_ASSERT_NEXT(a_last_idle, cmd_o.emit && stat.ser_last, state == IDLE && m_tvalid, "final byte did not end the report")
  `NKRO_ASSERT_NEXT(a_emit_valid, cmd_o.emit, m_tvalid, "emitted byte not presented")

endmodule

// ----- rtl/nkro_key_report_builder.sv -----
// Top level of the NKRO keyboard report builder: joins controller and
// datapath. Depends on nkro_pkg, nkro_ctrl and nkro_datapath.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    s_tdata: key/mods/consumer, s_tuser: cmd
//  m_*       out  m_tvalid/m_tready    m_tdata: byte and index, m_tlast: final byte
//  cfg_*     in   cfg_valid/cfg_ready  cfg_data: report id
//
// Non-serialize commands act when taken; a word is taken each cycle while idle.
// Serialize starts a report that leaves the output register one byte per cycle
// unless stalled: 23 bytes for the keyboard report, 3 for the consumer one.
// Input is held off until the final byte is loaded into the output register.
// Reset clears bitmap, modifiers and consumer code and sets the report id to 1.
// A stalled output holds its byte; the byte counter waits with it.
module nkro_key_report_builder
  import nkro_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [7:0] key_code, [8] pressed, [16:9] mod_bits, [32:17] consumer_code, rest zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [2:0] cmd
  input  logic [2:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [7:0] out_byte, [12:8] byte_index, rest zero
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);

  ctrl_cmd_t        ctl;
  dp_stat_t         stat;
  logic [7:0]       out_byte;
  logic [IDX_W-1:0] byte_index;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {(M_TDATA_W - 8 - IDX_W)'(0), byte_index, out_byte};

  nkro_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd_o    (ctl)
  );

  nkro_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd_i         (ctl),
    .stat          (stat),
    .cmd           (s_tuser),
    .key_code      (s_tdata[7:0]),
    .pressed       (s_tdata[8]),
    .mod_bits      (s_tdata[16:9]),
    .consumer_code (s_tdata[32:17]),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .out_byte      (out_byte),
    .byte_index    (byte_index),
    .last          (m_tlast)
  );

endmodule
